[rtl/core/lsp_pkg.sv]
package lsp_pkg;

   localparam int REFRACT_ENTRIES = 184;
   localparam int REFR_IDX_W      = 8;
   localparam int ANG_W           = 16;
   localparam int TRIG_W          = 18;
   localparam int DIM_W           = 14;
   localparam int SCALE_W         = 28;
   localparam int COORD_W         = 24;
   localparam int DEN_W           = 32;
   localparam int QUO_W           = 34;
   localparam int ROOT_W          = 17;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 28;
   localparam int SINCOS_LAT      = 4;
   localparam int KROOT_LAT       = QUO_W + ROOT_W;

   localparam int SIN_A = 51472;
   localparam int SIN_B = 21024;
   localparam int SIN_C = 2320;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_LON      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_LAT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_SCALE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZONTAL_MODE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTION_ON   = 3'd6;

   typedef logic signed [TRIG_W-1:0] trig_type;

   typedef struct packed {
      trig_type sin_val;
      trig_type cos_val;
   } sincos_type;

   typedef struct packed {
      logic [ANG_W-1:0]        point_lon;
      logic signed [ANG_W-1:0] point_lat;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
      logic                      visible;
   } rsp_type;

   typedef logic [15:0] rom_type [REFRACT_ENTRIES];

   function automatic longint sin_ref(longint a);
      longint s;
      longint m;
      longint z2;
      longint inner;
      longint mid;
      longint r;
      s = a & 65535;
      if (s >= 32768) s = s - 65536;
      if (s > 16384) s = 32768 - s;
      else if (s < -16384) s = -32768 - s;
      m = (s < 0) ? -s : s;
      z2 = (m * m + 8192) >>> 14;
      inner = SIN_B - ((z2 * SIN_C + 8192) >>> 14);
      mid = SIN_A - ((z2 * inner + 8192) >>> 14);
      r = (m * mid + 8192) >>> 14;
      return (s < 0) ? -r : r;
   endfunction

   // shift and subtract quotient of two non-negative values
   function automatic longint udiv_ref(longint n, longint d);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r << 1) | ((n >>> b) & 1);
         if (r >= d) begin
            r = r - d;
            q = q | (longint'(1) << b);
         end
      end
      return q;
   endfunction

   // correction for altitude -1.75 + 0.5 * i degrees
   function automatic rom_type build_rom();
      rom_type rom;
      longint am;
      longint den;
      longint hm;
      longint hba;
      longint sn;
      longint cs;
      longint corr;
      for (int i = 0; i < REFRACT_ENTRIES; i++) begin
         am = -1750 + 500 * longint'(i);
         den = am + 5110;
         hm = am + udiv_ref(10300000 + den / 2, den);
         hba = (hm * 65536 + 180000) / 360000;
         sn = sin_ref(hba);
         cs = sin_ref(hba + 16384);
         corr = 0;
         if (sn > 0 && cs >= 0) corr = udiv_ref(cs * 50704 + sn * 8192, sn * 16384);
         if (corr > 65535) corr = 65535;
         rom[i] = corr[15:0];
      end
      return rom;
   endfunction

   localparam rom_type REFR_ROM = build_rom();

endpackage

[rtl/core/lsp_sincos.sv]
module lsp_sincos (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [lsp_pkg::ANG_W-1:0]    angle,
   output lsp_pkg::sincos_type          result
);

   localparam int SIN_C_W = lsp_pkg::SIN_C;

   logic [14:0] m_ff [2][3];
   logic        neg_ff [2][3];
   logic [14:0] z2_ff [2][2];
   logic [14:0] inner_ff [2];
   logic [15:0] mid_ff [2];
   lsp_pkg::trig_type res_ff [2];

   logic [14:0] m_in [2];
   logic        neg_in [2];
   logic [14:0] z2_in [2];
   logic [14:0] inner_in [2];
   logic [15:0] mid_in [2];
   lsp_pkg::trig_type res_in [2];

   always_comb begin
      logic [15:0]        ang;
      logic signed [17:0] s;
      logic signed [17:0] f;
      logic [17:0]        mag;
      logic [28:0]        p1;
      logic [25:0]        p2;
      logic [29:0]        p3;
      logic [30:0]        p4;
      logic signed [17:0] r;
      for (int g = 0; g < 2; g++) begin
         ang = (g == 0) ? angle : angle + 16'd16384;
         s = 18'($signed(ang));
         if (s > 18'sd16384) f = 18'sd32768 - s;
         else if (s < -18'sd16384) f = -18'sd32768 - s;
         else f = s;
         neg_in[g] = f[17];
         mag = f[17] ? 18'(-f) : 18'(f);
         m_in[g] = mag[14:0];
         p1 = 29'(m_in[g]) * 29'(m_in[g]) + 29'd8192;
         z2_in[g] = p1[28:14];
         p2 = 26'(z2_ff[g][0]) * 26'(SIN_C_W) + 26'd8192;
         inner_in[g] = 15'(lsp_pkg::SIN_B) - {3'b000, p2[25:14]};
         p3 = 30'(z2_ff[g][1]) * 30'(inner_ff[g]) + 30'd8192;
         mid_in[g] = 16'(lsp_pkg::SIN_A) - p3[29:14];
         p4 = 31'(m_ff[g][2]) * 31'(mid_ff[g]) + 31'd8192;
         r = {1'b0, p4[30:14]};
         res_in[g] = neg_ff[g][2] ? -r : r;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int g = 0; g < 2; g++) begin
            m_ff[g][0]   <= m_in[g];
            m_ff[g][1]   <= m_ff[g][0];
            m_ff[g][2]   <= m_ff[g][1];
            neg_ff[g][0] <= neg_in[g];
            neg_ff[g][1] <= neg_ff[g][0];
            neg_ff[g][2] <= neg_ff[g][1];
            z2_ff[g][0]  <= z2_in[g];
            z2_ff[g][1]  <= z2_ff[g][0];
            inner_ff[g]  <= inner_in[g];
            mid_ff[g]    <= mid_in[g];
            res_ff[g]    <= res_in[g];
         end
      end
   end

   assign result.sin_val = res_ff[0];
   assign result.cos_val = res_ff[1];

endmodule

[rtl/core/lsp_kroot.sv]
module lsp_kroot (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [lsp_pkg::DEN_W-1:0]    den,
   output logic [lsp_pkg::ROOT_W-1:0]   root
);

   localparam int DSTEPS = lsp_pkg::QUO_W;
   localparam int RSTEPS = lsp_pkg::ROOT_W;
   localparam int DW     = lsp_pkg::DEN_W;
   localparam int QW     = lsp_pkg::QUO_W;
   localparam int RW     = QW + 1;
   localparam logic [DW-1:0] DIV_REM_INIT = DW'(64'd1 << (63 - DSTEPS));

   // restoring divide of 2^63 by den, then digit-by-digit square root
   logic [DW-1:0] drem_ff [DSTEPS];
   logic [DW-1:0] dden_ff [DSTEPS];
   logic [QW-1:0] dquo_ff [DSTEPS];
   logic [DW-1:0] drem_in [DSTEPS];
   logic [DW-1:0] dden_in [DSTEPS];
   logic [QW-1:0] dquo_in [DSTEPS];

   logic [QW-1:0] sn_ff [RSTEPS];
   logic [RW-1:0] sr_ff [RSTEPS];
   logic [QW-1:0] sn_in [RSTEPS];
   logic [RW-1:0] sr_in [RSTEPS];

   always_comb begin
      logic [DW-1:0] rs;
      logic [DW-1:0] ds;
      logic [QW-1:0] qs;
      logic [DW:0]   sh;
      for (int j = 0; j < DSTEPS; j++) begin
         if (j == 0) begin
            rs = DIV_REM_INIT;
            ds = den;
            qs = '0;
         end else begin
            rs = drem_ff[j-1];
            ds = dden_ff[j-1];
            qs = dquo_ff[j-1];
         end
         sh = {rs, 1'b0};
         if (sh >= {1'b0, ds}) begin
            drem_in[j] = DW'(sh - {1'b0, ds});
            dquo_in[j] = {qs[QW-2:0], 1'b1};
         end else begin
            drem_in[j] = sh[DW-1:0];
            dquo_in[j] = {qs[QW-2:0], 1'b0};
         end
         dden_in[j] = ds;
      end
   end

   always_comb begin
      logic [QW-1:0] ns;
      logic [RW-1:0] rsq;
      logic [RW-1:0] bitv;
      logic [RW-1:0] tv;
      for (int j = 0; j < RSTEPS; j++) begin
         if (j == 0) begin
            ns  = dquo_ff[DSTEPS-1];
            rsq = '0;
         end else begin
            ns  = sn_ff[j-1];
            rsq = sr_ff[j-1];
         end
         bitv = RW'(1) << (2 * (RSTEPS - 1 - j));
         tv = rsq + bitv;
         if ({1'b0, ns} >= tv) begin
            sn_in[j] = QW'({1'b0, ns} - tv);
            sr_in[j] = (rsq >> 1) + bitv;
         end else begin
            sn_in[j] = ns;
            sr_in[j] = rsq >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < DSTEPS; j++) begin
            drem_ff[j] <= drem_in[j];
            dden_ff[j] <= dden_in[j];
            dquo_ff[j] <= dquo_in[j];
         end
         for (int j = 0; j < RSTEPS; j++) begin
            sn_ff[j] <= sn_in[j];
            sr_ff[j] <= sr_in[j];
         end
      end
   end

   assign root = sr_ff[RSTEPS-1][lsp_pkg::ROOT_W-1:0];

endmodule

[rtl/core/lambert_sky_projection_core.sv]
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   lsp_pkg::req_type (point_lon, point_lat)
// rsp       out        rsp_valid / rsp_stall   lsp_pkg::rsp_type (screen_x, screen_y, visible)
// csr       in         csr_write_en            csr_index, csr_wdata
//
// one transaction per cycle while rsp_stall does not freeze the pipeline
// the 34-step divider and 17-step square root set most of the depth
// reset is synchronous, clears the valid bits and sets the csr registers to their defaults; the rom is constant
// rsp_stall freezes the whole pipeline while the output register holds data

module lambert_sky_projection_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lsp_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lsp_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_en,
   input  logic [lsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int KLAT  = lsp_pkg::KROOT_LAT;
   localparam int DEPTH = 2 + lsp_pkg::SINCOS_LAT + 3 + KLAT + 2;
   localparam int AW    = lsp_pkg::ANG_W;
   localparam int CW    = lsp_pkg::COORD_W;

   typedef struct packed {
      lsp_pkg::trig_type u;
      lsp_pkg::trig_type v;
      logic              vis;
   } side_type;

   logic [AW-1:0]               center_lon_ff;
   logic [AW-1:0]               center_lat_ff;
   logic [lsp_pkg::DIM_W-1:0]   screen_width_ff;
   logic [lsp_pkg::DIM_W-1:0]   screen_height_ff;
   logic [lsp_pkg::SCALE_W-1:0] pixel_scale_ff;
   logic                        horizontal_mode_ff;
   logic                        refraction_on_ff;

   logic                        en;
   logic                        vld_ff [DEPTH];
   logic                        rsp_valid_ff;
   lsp_pkg::rsp_type            rsp_data_ff;
   lsp_pkg::rsp_type            rsp_data_in;

   lsp_pkg::req_type            in_ff;
   logic [AW-1:0]               lat_eff_ff;
   logic [AW-1:0]               lat_eff_in;
   logic [AW-1:0]               dlon_ff;
   logic [AW-1:0]               dlon_in;

   lsp_pkg::sincos_type         sc_lat;
   lsp_pkg::sincos_type         sc_dlon;
   lsp_pkg::sincos_type         sc_ctr;

   lsp_pkg::trig_type           t_ff;
   lsp_pkg::trig_type           u6_ff;
   lsp_pkg::trig_type           sy0_ff;
   lsp_pkg::trig_type           cy0_ff;
   logic signed [35:0]          pa6_ff;
   logic signed [35:0]          cva6_ff;
   logic signed [35:0]          t_prod;
   logic signed [35:0]          u_prod;

   logic signed [35:0]          pa7_ff;
   logic signed [35:0]          pb7_ff;
   logic signed [35:0]          pc7_ff;
   logic signed [35:0]          cva7_ff;
   lsp_pkg::trig_type           u7_ff;

   logic [lsp_pkg::DEN_W-1:0]   den_ff;
   logic [lsp_pkg::DEN_W-1:0]   den_in;
   side_type                    side8_ff;
   side_type                    side8_in;
   side_type                    side_ff [KLAT];

   logic [lsp_pkg::ROOT_W-1:0]  k_root;
   logic signed [35:0]          ku_ff;
   logic signed [35:0]          kv_ff;
   logic                        vis1_ff;
   logic signed [63:0]          pu_ff;
   logic signed [63:0]          pv_ff;
   logic                        vis2_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_lon_ff      <= '0;
         center_lat_ff      <= '0;
         screen_width_ff    <= 14'd640;
         screen_height_ff   <= 14'd480;
         pixel_scale_ff     <= 28'd4096;
         horizontal_mode_ff <= 1'b0;
         refraction_on_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lsp_pkg::CSR_CENTER_LON:      center_lon_ff <= csr_wdata[AW-1:0];
            lsp_pkg::CSR_CENTER_LAT:      center_lat_ff <= csr_wdata[AW-1:0];
            lsp_pkg::CSR_SCREEN_WIDTH:    screen_width_ff <= csr_wdata[lsp_pkg::DIM_W-1:0];
            lsp_pkg::CSR_SCREEN_HEIGHT:   screen_height_ff <= csr_wdata[lsp_pkg::DIM_W-1:0];
            lsp_pkg::CSR_PIXEL_SCALE:     pixel_scale_ff <= csr_wdata;
            lsp_pkg::CSR_HORIZONTAL_MODE: horizontal_mode_ff <= csr_wdata[0];
            lsp_pkg::CSR_REFRACTION_ON:   refraction_on_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // refraction and longitude difference
   always_comb begin
      logic signed [24:0] lat_ext;
      logic signed [24:0] lat90;
      logic signed [24:0] idx_sum;
      logic [10:0]        idx_raw;
      logic [lsp_pkg::REFR_IDX_W-1:0] idx;
      lat_ext = 25'(in_ff.point_lat);
      lat90   = lat_ext * 25'sd90;
      idx_sum = lat_ext * 25'sd180 + 25'sd65536;
      idx_raw = idx_sum[24:14];
      if (idx_raw > 11'(lsp_pkg::REFRACT_ENTRIES - 1))
         idx = lsp_pkg::REFR_IDX_W'(lsp_pkg::REFRACT_ENTRIES - 1);
      else
         idx = idx_raw[lsp_pkg::REFR_IDX_W-1:0];
      lat_eff_in = in_ff.point_lat;
      if (horizontal_mode_ff && refraction_on_ff && lat90 > -25'sd32768)
         lat_eff_in = in_ff.point_lat + lsp_pkg::REFR_ROM[idx];
      if (horizontal_mode_ff)
         dlon_in = center_lon_ff - in_ff.point_lon;
      else
         dlon_in = in_ff.point_lon - center_lon_ff;
   end

   lsp_sincos u_sc_lat (
      .clock  (clock),
      .enable (en),
      .angle  (lat_eff_ff),
      .result (sc_lat)
   );

   lsp_sincos u_sc_dlon (
      .clock  (clock),
      .enable (en),
      .angle  (dlon_ff),
      .result (sc_dlon)
   );

   lsp_sincos u_sc_ctr (
      .clock  (clock),
      .enable (en),
      .angle  (center_lat_ff),
      .result (sc_ctr)
   );

   assign t_prod = $signed(sc_lat.cos_val) * $signed(sc_dlon.cos_val) + 36'sd16384;
   assign u_prod = $signed(sc_lat.cos_val) * $signed(sc_dlon.sin_val) + 36'sd16384;

   // cosine of the angular distance and the tilt term
   always_comb begin
      logic signed [36:0] c;
      logic signed [36:0] vs;
      c  = 37'(pa7_ff) + 37'(pb7_ff);
      vs = 37'(cva7_ff) - 37'(pc7_ff) + 37'sd16384;
      side8_in.u   = u7_ff;
      side8_in.v   = vs[32:15];
      side8_in.vis = !c[36];
      if (c[36])
         den_in = 32'd1 << 30;
      else if (c > 37'sd1073741824)
         den_in = 32'd1 << 31;
      else
         den_in = (32'd1 << 30) + c[31:0];
   end

   lsp_kroot u_kroot (
      .clock  (clock),
      .enable (en),
      .den    (den_ff),
      .root   (k_root)
   );

   // trunc toward zero of center offset minus scaled vector, then saturate; zero when not visible
   always_comb begin
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic signed [63:0] xq;
      logic signed [63:0] yq;
      xs = $signed({16'd0, screen_width_ff, 34'd0}) - pu_ff;
      ys = $signed({16'd0, screen_height_ff, 34'd0}) - pv_ff;
      xq = (xs + (xs[63] ? 64'sh7_FFFF_FFFF : 64'sd0)) >>> 35;
      yq = (ys + (ys[63] ? 64'sh7_FFFF_FFFF : 64'sd0)) >>> 35;
      if (xq > 64'sd8388607) rsp_data_in.screen_x = 24'sh7F_FFFF;
      else if (xq < -64'sd8388608) rsp_data_in.screen_x = 24'sh80_0000;
      else rsp_data_in.screen_x = xq[CW-1:0];
      if (yq > 64'sd8388607) rsp_data_in.screen_y = 24'sh7F_FFFF;
      else if (yq < -64'sd8388608) rsp_data_in.screen_y = 24'sh80_0000;
      else rsp_data_in.screen_y = yq[CW-1:0];
      rsp_data_in.visible = vis2_ff;
      if (!vis2_ff) begin
         rsp_data_in.screen_x = '0;
         rsp_data_in.screen_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff      <= req_data;
         lat_eff_ff <= lat_eff_in;
         dlon_ff    <= dlon_in;

         t_ff    <= t_prod[32:15];
         u6_ff   <= u_prod[32:15];
         sy0_ff  <= sc_ctr.sin_val;
         cy0_ff  <= sc_ctr.cos_val;
         pa6_ff  <= $signed(sc_ctr.sin_val) * $signed(sc_lat.sin_val);
         cva6_ff <= $signed(sc_ctr.cos_val) * $signed(sc_lat.sin_val);

         pa7_ff  <= pa6_ff;
         pb7_ff  <= cy0_ff * t_ff;
         pc7_ff  <= sy0_ff * t_ff;
         cva7_ff <= cva6_ff;
         u7_ff   <= u6_ff;

         den_ff   <= den_in;
         side8_ff <= side8_in;
         side_ff[0] <= side8_ff;
         for (int i = 1; i < KLAT; i++) side_ff[i] <= side_ff[i-1];

         ku_ff   <= $signed({1'b0, k_root}) * side_ff[KLAT-1].u;
         kv_ff   <= $signed({1'b0, k_root}) * side_ff[KLAT-1].v;
         vis1_ff <= side_ff[KLAT-1].vis;

         pu_ff   <= ku_ff * $signed({1'b0, pixel_scale_ff});
         pv_ff   <= kv_ff * $signed({1'b0, pixel_scale_ff});
         vis2_ff <= vis1_ff;

         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
